### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked property checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, ignored while reset is held.
`define HUF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define HUF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/huf_pkg.sv
// ----------------------------------------------------------------------------
// Huffman encoder package
// Sizes, item codes and queue types shared by the encoder modules.
// ----------------------------------------------------------------------------
package huf_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_WIDTH   = 32;
    localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_WIDTH) ? MAX_CODE_LEN : CODE_WIDTH;

    localparam int SYM_W     = 8;
    localparam int LEN_W     = 6;
    localparam int SYM_IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    // pending bits (at most seven) plus one full code
    localparam int ACC_W = LEN_CAP + 7;
    localparam int TOT_W = $clog2(ACC_W + 1);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_FLUSH  = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_ENCODE,
        OP_MISS,
        OP_FLUSH
    } t_op_kind;

    typedef struct packed {
        t_op_kind               kind;
        logic [CODE_WIDTH-1:0]  code;
        logic [LEN_W-1:0]       len;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_op_slot;

    typedef struct packed {
        logic [CODE_WIDTH-1:0] code;
        logic [LEN_W-1:0]      len;
    } t_entry;

endpackage

### rtl/huf_in_if.sv
// ----------------------------------------------------------------------------
// Encoder input channel
// Valid/ready channel carrying load, encode and flush transactions.
// ----------------------------------------------------------------------------
interface huf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_len;

    modport source (output valid, kind, symbol, code_bits, code_len, input ready);
    modport sink   (input valid, kind, symbol, code_bits, code_len, output ready);
endinterface

### rtl/huf_out_if.sv
// ----------------------------------------------------------------------------
// Encoder output channel
// Valid/ready channel carrying packed bytes and flush results.
// ----------------------------------------------------------------------------
interface huf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_data;
    logic [2:0] pad_bits;
    logic       last;
    logic       missing_seen;

    modport source (output valid, data_byte, has_data, pad_bits, last, missing_seen,
                    input ready);
    modport sink   (input valid, data_byte, has_data, pad_bits, last, missing_seen,
                    output ready);
endinterface

### rtl/huf_queue.sv
// ----------------------------------------------------------------------------
// Encoder operation queue
// Short FIFO of classified operations between front and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huf_queue import huf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_op_slot           i_push,
    input  logic               i_pop,
    output t_op_slot           o_head,
    output logic [Q_CNT_W-1:0] o_count
);

    t_op                r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wr_ptr] <= i_push.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.op    = r_slot[r_rd_ptr];
    assign o_count      = r_count;

    `HUF_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push.valid |-> (r_count < Q_CNT_W'(Q_DEPTH)), "queue overflow")
    `HUF_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> (r_count != '0), "queue underflow")

endmodule

### rtl/huf_front.sv
// ----------------------------------------------------------------------------
// Encoder front end
// Accept transactions, keep the code table and classify encode and flush.
// ----------------------------------------------------------------------------
module huf_front import huf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    huf_in_if.sink             i_in,
    input  logic [Q_CNT_W-1:0] i_q_count,
    output t_op_slot           o_push
);

    t_entry                  r_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_valid;
    t_entry                  r_rd;
    logic                    r_s1_valid;
    logic                    r_s1_flush;
    logic                    r_s1_hit;

    logic                  accept;
    logic                  in_range;
    logic [SYM_IDX_W-1:0]  idx;
    logic                  is_load;
    logic                  is_encode;
    logic                  is_flush;
    logic [LEN_W-1:0]      sat_len;
    logic [CODE_WIDTH-1:0] mask;

    // room for the transaction in flight as well as the queued ones
    assign i_in.ready = (int'(i_q_count) + int'(r_s1_valid)) < Q_DEPTH;
    assign accept     = i_in.valid && i_in.ready;

    assign in_range  = ({1'b0, i_in.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign idx       = i_in.symbol[SYM_IDX_W-1:0];
    assign is_load   = (i_in.kind == KIND_LOAD);
    assign is_encode = (i_in.kind == KIND_ENCODE);
    assign is_flush  = (i_in.kind == KIND_FLUSH);
    assign sat_len   = (int'(i_in.code_len) > LEN_CAP) ? LEN_W'(LEN_CAP) : i_in.code_len;

    // table write and registered read share one port pair
    always_ff @(posedge i_clk) begin
        if (accept && is_load && in_range) begin
            r_mem[idx] <= '{code: i_in.code_bits, len: sat_len};
        end
        if (accept && is_encode) begin
            r_rd <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept && is_load && in_range) begin
                r_valid[idx] <= 1'b1;
            end
            r_s1_valid <= accept && (is_encode || is_flush);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flush <= is_flush;
            r_s1_hit   <= in_range && r_valid[idx];
        end
    end

    always_comb begin
        for (int i = 0; i < CODE_WIDTH; i++) begin
            mask[i] = (i < int'(r_rd.len));
        end
    end

    always_comb begin
        o_push.valid   = r_s1_valid;
        o_push.op.code = r_rd.code & mask;
        o_push.op.len  = r_rd.len;
        if (r_s1_flush) begin
            o_push.op.kind = OP_FLUSH;
        end else if (r_s1_hit) begin
            o_push.op.kind = OP_ENCODE;
        end else begin
            o_push.op.kind = OP_MISS;
        end
    end

endmodule

### rtl/huf_back.sv
// ----------------------------------------------------------------------------
// Encoder back end
// Pack bits into bytes, emit one byte a cycle unless stalled, answer flushes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huf_back import huf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_op_slot i_head,
    output logic     o_pop,
    huf_out_if.source o_out
);

    logic [ACC_W-1:0] r_acc;
    logic [TOT_W-1:0] r_total;
    logic             r_miss;
    logic             r_o_valid;
    logic [7:0]       r_o_data;
    logic             r_o_has;
    logic [2:0]       r_o_pad;
    logic             r_o_last;
    logic             r_o_miss;

    logic             out_free;
    logic             have_byte;
    logic             emit;
    logic [TOT_W-1:0] rem_total;
    logic [7:0]       cur_byte;
    logic [2:0]       pend;
    logic [3:0]       pad_sh;
    logic [7:0]       flush_data;
    logic             pop_flush;
    logic             pop_encode;
    logic             pop_miss;
    logic             flush_done;

    assign out_free  = !r_o_valid || o_out.ready;
    assign have_byte = (r_total >= TOT_W'(8));
    assign emit      = have_byte && out_free;
    assign rem_total = r_total - TOT_W'(8);
    assign cur_byte  = 8'(r_acc >> rem_total);

    // drain whole bytes before taking the next operation
    assign o_pop      = !have_byte && i_head.valid && ((i_head.op.kind != OP_FLUSH) || out_free);
    assign pop_flush  = o_pop && (i_head.op.kind == OP_FLUSH);
    assign pop_encode = o_pop && (i_head.op.kind == OP_ENCODE);
    assign pop_miss   = o_pop && (i_head.op.kind == OP_MISS);

    assign pend       = r_total[2:0];
    assign pad_sh     = 4'd8 - {1'b0, pend};
    assign flush_data = r_acc[7:0] << pad_sh;
    assign flush_done = (r_total == '0) && !r_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_miss    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_total <= rem_total;
            end else if (pop_encode) begin
                r_total <= r_total + TOT_W'(i_head.op.len);
            end else if (pop_flush) begin
                r_total <= '0;
            end
            if (pop_miss) begin
                r_miss <= 1'b1;
            end else if (pop_flush) begin
                r_miss <= 1'b0;
            end
            if (emit || pop_flush) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_encode) begin
            r_acc <= (r_acc << i_head.op.len) | ACC_W'(i_head.op.code);
        end
        if (emit) begin
            r_o_data <= cur_byte;
            r_o_has  <= 1'b1;
            r_o_pad  <= '0;
            r_o_last <= (rem_total < TOT_W'(8));
            r_o_miss <= 1'b0;
        end else if (pop_flush) begin
            r_o_data <= (pend != '0) ? flush_data : '0;
            r_o_has  <= (pend != '0);
            r_o_pad  <= (pend != '0) ? pad_sh[2:0] : '0;
            r_o_last <= 1'b1;
            r_o_miss <= r_miss;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.data_byte    = r_o_data;
    assign o_out.has_data     = r_o_has;
    assign o_out.pad_bits     = r_o_pad;
    assign o_out.last         = r_o_last;
    assign o_out.missing_seen = r_o_miss;

    `HUF_ASSERT(a_flush_clears, i_clk, i_rst_n, pop_flush |=> flush_done, "flush left state")
    `HUF_ASSERT(a_total_bound, i_clk, i_rst_n, r_total <= TOT_W'(ACC_W), "bit count overrun")

endmodule

### rtl/huffman_table_encoder_packer_unit.sv
// ----------------------------------------------------------------------------
// Table-driven Huffman encoder with MSB-first byte packer
// Usage: drive transactions on i_in (kind, symbol, code_bits, code_len) and
// take results from o_out (data_byte, has_data, pad_bits, last, missing_seen).
// A load writes one symbol's code into the table and yields no result.
// An encode appends that symbol's code; each completed byte is a result,
// the last byte of an encode carries last. An encode of a symbol with no
// table entry yields nothing and raises the missing flag.
// A flush returns one result: the padded partial byte, or an empty result,
// plus the missing flag, and clears pending bits and flag. Kind 3 is dropped.
// Throughput: one transaction per cycle while encodes complete no byte and
// the receiver takes flush results; each output byte stalls the back end,
// which has a single byte extractor. Each transaction passes the front-end
// register and the queue before the back end answers it.
// Reset clears the table valid bits, pending bits and flag.
// A stalled receiver holds the output register; the front end keeps taking
// transactions until the four-entry queue fills, then drops i_in.ready.
// ----------------------------------------------------------------------------
module huffman_table_encoder_packer_unit import huf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    huf_in_if.sink    i_in,
    huf_out_if.source o_out
);

    t_op_slot           push;
    t_op_slot           head;
    logic               pop;
    logic [Q_CNT_W-1:0] q_count;

    // classify transactions and look up codes
    huf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_count (q_count),
        .o_push    (push)
    );

    // decouple lookup from packing
    huf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_count)
    );

    // pack bits and emit bytes
    huf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

### tb/sv/huffman_table_encoder_packer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Regression bench for the table-driven Huffman encoder and byte packer
// Loads code tables, encodes symbol streams and flushes, predicting every
// packed byte in a local copy of the table and bit packer and comparing each
// output transaction in order, under random stalls on both channels.
// ----------------------------------------------------------------------------
module huffman_table_encoder_packer_unit_test;
    import huf_pkg::*;

    // Output transaction as seen on o_out.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic [2:0] pad_bits;
        logic       last;
        logic       missing_seen;
    } packed_byte_t;

    localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
    localparam int DRAIN_TAIL     = 12;    // settle time for transactions with no result
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
    localparam int POOL_SIZE      = 24;

    logic i_clk;
    logic i_rst_n;

    huf_in_if  in_ch ();
    huf_out_if out_ch ();

    huffman_table_encoder_packer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Local copy of the code table and the bit packer.
    logic [31:0]  table_code  [SYMBOL_COUNT];
    int unsigned  table_len   [SYMBOL_COUNT];
    bit           table_valid [SYMBOL_COUNT];
    logic [6:0]   pend_bits;
    int unsigned  pend_cnt;
    bit           miss_flag;

    packed_byte_t expected_bytes [$];

    int  fail_count;
    int  idle_cycles;
    bit  tx_calm;       // sender offers back to back while set
    bit  rx_calm;       // receiver ready without gaps while set, outside a hold-off
    bit  hold_req;      // ask the receiver for a long hold-off

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction: apply one accepted transaction to the local table and
    // packer, and queue every byte that it completes.
    // ------------------------------------------------------------------------
    function automatic void predict_packer_output(t_kind kind, logic [7:0] sym,
                                                  logic [31:0] code, logic [5:0] len);
        logic [63:0]  acc;
        logic [63:0]  code_masked;
        int unsigned  n_len;
        int unsigned  total;
        int unsigned  pad;
        packed_byte_t res;
        case (kind)
            KIND_LOAD: begin
                // Saturate overlong lengths; drop symbols beyond the table.
                if (int'(sym) < SYMBOL_COUNT) begin
                    table_code[sym]  = code;
                    table_len[sym]   = (int'(len) > LEN_CAP) ? LEN_CAP : len;
                    table_valid[sym] = 1'b1;
                end
            end
            KIND_ENCODE: begin
                if (int'(sym) >= SYMBOL_COUNT || !table_valid[sym]) begin
                    // Missing entry: emit nothing, keep pending bits.
                    miss_flag = 1'b1;
                end else begin
                    n_len       = table_len[sym];
                    code_masked = {32'b0, table_code[sym]} & ((64'd1 << n_len) - 64'd1);
                    acc         = ({57'b0, pend_bits} << n_len) | code_masked;
                    total       = pend_cnt + n_len;
                    while (total >= 8) begin
                        res.data_byte    = 8'(acc >> (total - 8));
                        res.has_data     = 1'b1;
                        res.pad_bits     = 3'd0;
                        res.last         = (total - 8 < 8);
                        res.missing_seen = 1'b0;
                        expected_bytes.push_back(res);
                        total -= 8;
                    end
                    pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
                    pend_cnt  = total;
                end
            end
            KIND_FLUSH: begin
                // Pad the partial byte with zeros, or report an empty flush.
                res.has_data     = (pend_cnt != 0);
                pad              = res.has_data ? 8 - pend_cnt : 0;
                res.pad_bits     = 3'(pad);
                res.data_byte    = res.has_data ? 8'({1'b0, pend_bits} << pad) : 8'd0;
                res.last         = 1'b1;
                res.missing_seen = miss_flag;
                expected_bytes.push_back(res);
                pend_bits = 7'd0;
                pend_cnt  = 0;
                miss_flag = 1'b0;
            end
            default: begin
                // Unused kind: dropped by the block.
            end
        endcase
    endfunction

    function automatic void report_mismatch(string what, packed_byte_t want,
                                            packed_byte_t got);
        if (fail_count < 10) begin
            $display("%0t: %s: expected byte=%h has=%b pad=%0d last=%b miss=%b,",
                     $realtime, what, want.data_byte, want.has_data, want.pad_bits,
                     want.last, want.missing_seen);
            $display("    got byte=%h has=%b pad=%0d last=%b miss=%b",
                     got.data_byte, got.has_data, got.pad_bits, got.last,
                     got.missing_seen);
        end
        fail_count++;
    endfunction

    // ------------------------------------------------------------------------
    // Input monitor: predict from every accepted input transaction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_packer_output(t_kind'(in_ch.kind), in_ch.symbol,
                                  in_ch.code_bits, in_ch.code_len);
        end
    end

    // ------------------------------------------------------------------------
    // Output checker: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        packed_byte_t got;
        packed_byte_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.data_byte, out_ch.has_data, out_ch.pad_bits,
                    out_ch.last, out_ch.missing_seen};
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = expected_bytes.pop_front();
                if (got.data_byte !== want.data_byte || got.has_data !== want.has_data ||
                    got.pad_bits !== want.pad_bits || got.last !== want.last ||
                    got.missing_seen !== want.missing_seen) begin
                    report_mismatch("mismatch", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when neither channel moves for too long.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("huffman_table_encoder_packer_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Gap length: mostly none or short, now and then long; none while calm.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stalls, calm stretches, and the long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin
        int n;
        out_ch.ready <= 1'b0;
        forever begin
            if (hold_req) begin
                // Hold off while the sender keeps offering; the block backs up.
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) begin
                    rx_calm = !rx_calm;
                end
                n = pick_gap(rx_calm);
                if (n > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: offer one transaction, hold it until accepted, then idle a while.
    // Valid stays high when no gap follows, so back-to-back items never toggle it.
    // ------------------------------------------------------------------------
    task automatic send_item(t_kind kind, logic [7:0] sym, logic [31:0] code,
                             logic [5:0] len);
        int n;
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.symbol    <= sym;
        in_ch.code_bits <= code;
        in_ch.code_len  <= len;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n = pick_gap(tx_calm);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected result has come, then let
    // the pipeline settle for transactions that cause no result.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    function automatic logic [5:0] rand_code_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return 6'd0;
        end else if (r < 70) begin
            return 6'($urandom_range(1, 8));
        end else if (r < 90) begin
            return 6'($urandom_range(9, 16));
        end else if (r < 97) begin
            return 6'($urandom_range(17, 32));
        end
        return 6'($urandom_range(33, 63));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Flush straight after reset: empty result, flag clear.
    task automatic test_empty_flush();
        send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
        wait_drained();
    endtask

    // Encode a symbol with no table entry, then flush twice: the flag is
    // reported once and cleared by the first flush.
    task automatic test_missing_symbol();
        send_item(KIND_ENCODE, 8'hFF, 32'h0, 6'd0);
        send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
        send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
        wait_drained();
    endtask

    // Table extremes: zero length, full 32-bit code, saturated length,
    // the unused kind, encodes with and without a full byte, padded flushes.
    task automatic test_table_extremes();
        send_item(KIND_LOAD, 8'h00, 32'h0000_0000, 6'd0);
        send_item(KIND_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
        send_item(KIND_LOAD, 8'h01, 32'h8000_0001, 6'd63);
        send_item(KIND_LOAD, 8'h02, 32'h0000_0155, 6'd9);
        send_item(KIND_LOAD, 8'h03, 32'h0000_0001, 6'd1);
        send_item(KIND_UNUSED, 8'hAA, 32'h5555_AAAA, 6'h2A);
        send_item(KIND_ENCODE, 8'h00, 32'h0, 6'd0);
        send_item(KIND_ENCODE, 8'h03, 32'h0, 6'd0);
        send_item(KIND_ENCODE, 8'hFF, 32'h0, 6'd0);
        send_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0);
        send_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0);
        send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
        send_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0);
        send_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0);
        send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
        // Eight one-bit codes complete exactly one byte; the flush is empty.
        for (int i = 0; i < 8; i++) begin
            send_item(KIND_ENCODE, 8'h03, 32'h0, 6'd0);
        end
        send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
        wait_drained();
    endtask

    // Long receiver hold-off under a steady stream of four-byte codes:
    // the queue fills and the input must stall without losing anything.
    task automatic test_output_backpressure();
        bit calm_saved;
        calm_saved = tx_calm;
        send_item(KIND_LOAD, 8'h80, $urandom, 6'd32);
        tx_calm  = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++) begin
            send_item(KIND_ENCODE, 8'h80, 32'h0, 6'd0);
        end
        send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
        tx_calm = calm_saved;
        wait_drained();
    endtask

    // Random streams: a table of pooled symbols, then mostly encodes of pooled
    // symbols with flushes, reloads, stray symbols and the odd unused kind.
    task automatic test_random_stream();
        logic [7:0] pool [POOL_SIZE];
        int         r;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool[i] = 8'($urandom_range(0, 255));
            send_item(KIND_LOAD, pool[i], $urandom, rand_code_len());
        end
        for (int i = 0; i < 270; i++) begin
            if ($urandom_range(0, 39) == 0) begin
                tx_calm = !tx_calm;
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_item(KIND_ENCODE, pool[$urandom_range(0, POOL_SIZE - 1)],
                          $urandom, 6'($urandom));
            end else if (r < 76) begin
                send_item(KIND_ENCODE, 8'($urandom), $urandom, 6'($urandom));
            end else if (r < 85) begin
                send_item(KIND_FLUSH, 8'($urandom), $urandom, 6'($urandom));
            end else if (r < 92) begin
                send_item(KIND_LOAD, pool[$urandom_range(0, POOL_SIZE - 1)],
                          $urandom, rand_code_len());
            end else if (r < 97) begin
                send_item(KIND_LOAD, 8'($urandom), $urandom, rand_code_len());
            end else begin
                send_item(KIND_UNUSED, 8'($urandom), $urandom, 6'($urandom));
            end
        end
        send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
        tx_calm = 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        fail_count  = 0;
        idle_cycles = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        hold_req    = 1'b0;
        pend_bits   = 7'd0;
        pend_cnt    = 0;
        miss_flag   = 1'b0;
        for (int i = 0; i < SYMBOL_COUNT; i++) begin
            table_valid[i] = 1'b0;
        end

        // Hold every input at a known value through reset.
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.kind      <= KIND_LOAD;
        in_ch.symbol    <= 8'h00;
        in_ch.code_bits <= 32'h0;
        in_ch.code_len  <= 6'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_flush();
        test_missing_symbol();
        test_table_extremes();
        test_output_backpressure();
        test_random_stream();

        if (fail_count == 0 && expected_bytes.size() == 0) begin
            $display("huffman_table_encoder_packer_unit regression: pass");
        end else begin
            $display("huffman_table_encoder_packer_unit regression: fail");
        end
        $finish;
    end

endmodule
